@@ hw/rtl/mff_pkg.sv @@
// Shared types and constants for the motor feedback filter.
// No dependencies; imported by every module of the block.
package mff_pkg;

   // field widths
   localparam int ID_W     = 11;
   localparam int BYTE_W   = 8;
   localparam int POS_W    = 16;
   localparam int WORD_W   = 16;
   localparam int SCALE_W  = 24;
   localparam int WRAP_W   = 18;
   localparam int DIFF_W   = 19;
   localparam int PROD_W   = SCALE_W + 1 + DIFF_W;
   localparam int ANGLE_W  = 48;

   // csr port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;

   // pipeline depths of the arithmetic units
   localparam int CDIV_STAGES  = 5;
   localparam int ANGLE_STAGES = 2;

   // register reset values
   localparam logic [ID_W-1:0]    MOTOR_ID_RST    = 11'd513;
   localparam logic [POS_W-1:0]   ENC_ZERO_RST    = 16'd0;
   localparam logic [POS_W-1:0]   ECD_RANGE_RST   = 16'd8192;
   localparam logic [SCALE_W-1:0] ANGLE_SCALE_RST = 24'd2880;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MOTOR_ID    = 2'd0,
      CSR_ENC_ZERO    = 2'd1,
      CSR_ECD_RANGE   = 2'd2,
      CSR_ANGLE_SCALE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SCALE_W-1:0] angle_scale;
      logic [POS_W-1:0]   ecd_full_range;
      logic [POS_W-1:0]   enc_zero;
      logic [ID_W-1:0]    motor_id;
   } cfg_type;

   // input word, frame_id in the lowest bits, pad in the highest
   typedef struct packed {
      logic [4:0]        pad;
      logic [BYTE_W-1:0] byte_6;
      logic [BYTE_W-1:0] byte_5;
      logic [BYTE_W-1:0] byte_4;
      logic [BYTE_W-1:0] byte_3;
      logic [BYTE_W-1:0] byte_2;
      logic [BYTE_W-1:0] byte_1;
      logic [BYTE_W-1:0] byte_0;
      logic [ID_W-1:0]   frame_id;
   } req_data_type;

   // decoded frame fields carried down the pipeline
   typedef struct packed {
      logic [BYTE_W-1:0]        temperature;
      logic signed [WORD_W-1:0] torque_current;
      logic signed [WORD_W-1:0] speed_rpm;
      logic [POS_W-1:0]         previous_position;
      logic [POS_W-1:0]         raw_position;
   } fb_type;

   // result word, raw_position in the lowest bits, pad in the highest
   typedef struct packed {
      logic [3:0]                pad;
      logic signed [ANGLE_W-1:0] mean_angle;
      logic signed [WRAP_W-1:0]  mean_position_wrapped;
      logic signed [WORD_W-1:0]  mean_speed;
      logic signed [ANGLE_W-1:0] angle;
      logic signed [WRAP_W-1:0]  wrapped_position;
      logic [BYTE_W-1:0]         temperature;
      logic signed [WORD_W-1:0]  torque_current;
      logic signed [WORD_W-1:0]  speed_rpm;
      logic [POS_W-1:0]          previous_position;
      logic [POS_W-1:0]          raw_position;
   } rsp_data_type;

endpackage

@@ hw/rtl/mff_window.sv @@
// Frame match, field decode, sample window and running totals.
// Depends on mff_pkg.
module mff_window #(
   parameter int WINDOW = 20,
   parameter int TOT_W  = 21
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     take,
   input  mff_pkg::req_data_type    frame,
   input  logic [mff_pkg::ID_W-1:0] motor_id,
   output logic                     hit,
   output mff_pkg::fb_type          fb,
   output logic [TOT_W-1:0]         pos_total,
   output logic [TOT_W-1:0]         spd_total
);
   import mff_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

   logic [POS_W-1:0]         pos_win_ff [WINDOW];
   logic signed [WORD_W-1:0] spd_win_ff [WINDOW];
   logic [SLOT_W-1:0]        slot_ff;
   logic [TOT_W-1:0]         pos_sum_ff;
   logic signed [TOT_W-1:0]  spd_sum_ff;
   logic [POS_W-1:0]         last_pos_ff;

   logic                     hit_ff;
   fb_type                   fb_ff;
   logic [TOT_W-1:0]         pos_tot_ff;
   logic [TOT_W-1:0]         spd_tot_ff;

   logic                     match;
   logic                     upd;
   logic [POS_W-1:0]         raw;
   logic signed [WORD_W-1:0] speed;
   logic signed [WORD_W-1:0] current;
   logic [TOT_W-1:0]         pos_sum_in;
   logic signed [TOT_W-1:0]  spd_sum_in;
   logic [SLOT_W-1:0]        slot_in;

   // decode and running totals: add the new sample, drop the oldest
   always_comb begin
      match   = (frame.frame_id == motor_id);
      upd     = take && match;
      raw     = {frame.byte_0, frame.byte_1};
      speed   = $signed({frame.byte_2, frame.byte_3});
      current = $signed({frame.byte_4, frame.byte_5});
      pos_sum_in = pos_sum_ff + TOT_W'(raw) - TOT_W'(pos_win_ff[slot_ff]);
      spd_sum_in = spd_sum_ff + TOT_W'(speed) - TOT_W'(spd_win_ff[slot_ff]);
      slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   end

   // window state, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            pos_win_ff[i] <= '0;
            spd_win_ff[i] <= '0;
         end
         slot_ff     <= '0;
         pos_sum_ff  <= '0;
         spd_sum_ff  <= '0;
         last_pos_ff <= '0;
      end else if (upd) begin
         pos_win_ff[slot_ff] <= raw;
         spd_win_ff[slot_ff] <= speed;
         slot_ff     <= slot_in;
         pos_sum_ff  <= pos_sum_in;
         spd_sum_ff  <= spd_sum_in;
         last_pos_ff <= raw;
      end
   end

   // first pipeline stage: valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (advance) begin
         hit_ff <= upd;
      end
   end

   // first pipeline stage: payload
   always_ff @(posedge clock) begin
      if (advance) begin
         fb_ff.raw_position      <= raw;
         fb_ff.previous_position <= last_pos_ff;
         fb_ff.speed_rpm         <= speed;
         fb_ff.torque_current    <= current;
         fb_ff.temperature       <= frame.byte_6;
         pos_tot_ff              <= pos_sum_in;
         spd_tot_ff              <= spd_sum_in;
      end
   end

   assign hit       = hit_ff;
   assign fb        = fb_ff;
   assign pos_total = pos_tot_ff;
   assign spd_total = spd_tot_ff;

endmodule

@@ hw/rtl/mff_cdiv.sv @@
// Pipelined divide by a constant, truncating toward zero.
// Reciprocal multiply with one correction step; depends on mff_pkg.
module mff_cdiv #(
   parameter int X_W = 21,
   parameter int DIV = 20
) (
   input  logic           clock,
   input  logic           advance,
   input  logic           is_signed,
   input  logic [X_W-1:0] x,
   output logic [X_W-1:0] q
);
   import mff_pkg::*;

   // floor(2^X_W / DIV): estimate is low by at most one
   localparam longint unsigned RECIP_L = (64'd1 << X_W) / DIV;
   localparam logic [X_W-1:0]  RECIP   = X_W'(RECIP_L);
   localparam logic [X_W-1:0]  DIV_X   = X_W'(DIV);

   logic             neg_a_ff, neg_b_ff, neg_c_ff, neg_d_ff;
   logic [X_W-1:0]   mag_a_ff, mag_b_ff, mag_c_ff;
   logic [2*X_W-1:0] prod_b_ff;
   logic [X_W-1:0]   q_c_ff, qw_c_ff, q_d_ff, q_e_ff;

   logic             neg_in;
   logic [X_W-1:0]   q_est;
   logic [X_W-1:0]   rem;

   always_comb begin
      neg_in = is_signed && x[X_W-1];
      q_est  = prod_b_ff[2*X_W-1:X_W];
      rem    = mag_c_ff - qw_c_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // magnitude
         neg_a_ff  <= neg_in;
         mag_a_ff  <= neg_in ? (~x + 1'b1) : x;
         // reciprocal product
         neg_b_ff  <= neg_a_ff;
         mag_b_ff  <= mag_a_ff;
         prod_b_ff <= (2*X_W)'(mag_a_ff) * (2*X_W)'(RECIP);
         // estimate and its back product
         neg_c_ff  <= neg_b_ff;
         mag_c_ff  <= mag_b_ff;
         q_c_ff    <= q_est;
         qw_c_ff   <= q_est * DIV_X;
         // correction
         neg_d_ff  <= neg_c_ff;
         q_d_ff    <= (rem >= DIV_X) ? q_c_ff + 1'b1 : q_c_ff;
         // restore sign
         q_e_ff    <= neg_d_ff ? (~q_d_ff + 1'b1) : q_d_ff;
      end
   end

   assign q = q_e_ff;

endmodule

@@ hw/rtl/mff_angle.sv @@
// Offset wrap of an encoder position and Q16 angle scaling, two stages.
// Depends on mff_pkg.
module mff_angle (
   input  logic                                clock,
   input  logic                                advance,
   input  mff_pkg::cfg_type                    cfg,
   input  logic [mff_pkg::POS_W-1:0]           pos,
   output logic signed [mff_pkg::WRAP_W-1:0]   wrapped,
   output logic signed [mff_pkg::ANGLE_W-1:0]  angle
);
   import mff_pkg::*;

   logic [POS_W-1:0]         half;
   logic [POS_W:0]           hi_thr;
   logic [POS_W-1:0]         lo_thr;
   logic signed [DIFF_W-1:0] pos_s, rng_s, off_s, wrap_s, diff_s;
   logic signed [SCALE_W:0]  scale_s;
   logic signed [PROD_W-1:0] prod;

   logic signed [WRAP_W-1:0] wrap_a_ff, wrap_b_ff;
   logic signed [DIFF_W-1:0] diff_a_ff;
   logic signed [ANGLE_W-1:0] angle_b_ff;

   // wrap by one full range toward the offset
   always_comb begin
      half   = {1'b0, cfg.ecd_full_range[POS_W-1:1]};
      hi_thr = {1'b0, cfg.enc_zero} + {1'b0, half};
      lo_thr = cfg.enc_zero - half;
      pos_s  = $signed({{(DIFF_W-POS_W){1'b0}}, pos});
      rng_s  = $signed({{(DIFF_W-POS_W){1'b0}}, cfg.ecd_full_range});
      off_s  = $signed({{(DIFF_W-POS_W){1'b0}}, cfg.enc_zero});
      wrap_s = pos_s;
      if (cfg.enc_zero < half) begin
         if ({1'b0, pos} > hi_thr) begin
            wrap_s = pos_s - rng_s;
         end
      end else if (pos < lo_thr) begin
         wrap_s = pos_s + rng_s;
      end
      diff_s = wrap_s - off_s;
   end

   // scale the distance from offset
   always_comb begin
      scale_s = $signed({1'b0, cfg.angle_scale});
      prod    = scale_s * diff_a_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wrap_a_ff  <= wrap_s[WRAP_W-1:0];
         diff_a_ff  <= diff_s;
         wrap_b_ff  <= wrap_a_ff;
         angle_b_ff <= {{(ANGLE_W-PROD_W){prod[PROD_W-1]}}, prod};
      end
   end

   assign wrapped = wrap_b_ff;
   assign angle   = angle_b_ff;

endmodule

@@ hw/rtl/motor_feedback_filter_core.sv @@
// Motor feedback filter: decode, windowed mean of position and speed, angle.
// A frame accepted on req passes the window stage, the divider stages and the angle stages before rsp_tvalid rises;
// throughput is one word per cycle while rsp_tready stays high.
// A stalled result moves into a skid register; req_tready is low while it holds a word.
// Synchronous reset clears the sample windows, totals, slot and registers to defaults.
module motor_feedback_filter_core #(
   parameter int WINDOW = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  mff_pkg::req_data_type              req_tdata,  // frame_id, byte_0 .. byte_6
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // raw_position, previous_position, speed_rpm, torque_current, temperature,
   // wrapped_position, angle, mean_speed, mean_position_wrapped, mean_angle
   output mff_pkg::rsp_data_type              rsp_tdata,
   // register write port
   input  logic                               csr_we,
   input  mff_pkg::csr_index_type             csr_addr,
   input  logic [mff_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mff_pkg::*;

   localparam int TOT_W = POS_W + $clog2(WINDOW);
   localparam int LAT   = CDIV_STAGES + ANGLE_STAGES;

   cfg_type                   cfg_ff;
   logic [LAT-1:0]            vld_ff;
   fb_type                    fb_pipe_ff [LAT];
   logic signed [WORD_W-1:0]  mspd_pipe_ff [ANGLE_STAGES];
   logic                      skid_valid_ff;
   rsp_data_type              skid_data_ff;

   logic                      advance;
   logic                      take;
   logic                      hit;
   fb_type                    fb1;
   logic [TOT_W-1:0]          pos_total;
   logic [TOT_W-1:0]          spd_total;
   logic [TOT_W-1:0]          pos_mean;
   logic [TOT_W-1:0]          spd_mean;
   logic signed [WRAP_W-1:0]  raw_wrapped, mean_wrapped;
   logic signed [ANGLE_W-1:0] raw_angle, mean_angle;
   logic                      o_valid;
   rsp_data_type              o_data;

   // handshake: the pipeline moves whenever the skid register is free
   assign advance    = !skid_valid_ff;
   assign req_tready = advance;
   assign take       = req_tvalid && advance;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motor_id       <= MOTOR_ID_RST;
         cfg_ff.enc_zero       <= ENC_ZERO_RST;
         cfg_ff.ecd_full_range <= ECD_RANGE_RST;
         cfg_ff.angle_scale    <= ANGLE_SCALE_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MOTOR_ID:    cfg_ff.motor_id       <= csr_wdata[ID_W-1:0];
            CSR_ENC_ZERO:    cfg_ff.enc_zero       <= csr_wdata[POS_W-1:0];
            CSR_ECD_RANGE:   cfg_ff.ecd_full_range <= csr_wdata[POS_W-1:0];
            CSR_ANGLE_SCALE: cfg_ff.angle_scale    <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   mff_window #(
      .WINDOW (WINDOW),
      .TOT_W  (TOT_W)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .take      (take),
      .frame     (req_tdata),
      .motor_id  (cfg_ff.motor_id),
      .hit       (hit),
      .fb        (fb1),
      .pos_total (pos_total),
      .spd_total (spd_total)
   );

   mff_cdiv #(
      .X_W (TOT_W),
      .DIV (WINDOW)
   ) u_pos_div (
      .clock     (clock),
      .advance   (advance),
      .is_signed (1'b0),
      .x         (pos_total),
      .q         (pos_mean)
   );

   mff_cdiv #(
      .X_W (TOT_W),
      .DIV (WINDOW)
   ) u_spd_div (
      .clock     (clock),
      .advance   (advance),
      .is_signed (1'b1),
      .x         (spd_total),
      .q         (spd_mean)
   );

   // raw position enters its angle unit in step with the mean
   mff_angle u_raw_angle (
      .clock   (clock),
      .advance (advance),
      .cfg     (cfg_ff),
      .pos     (fb_pipe_ff[CDIV_STAGES-1].raw_position),
      .wrapped (raw_wrapped),
      .angle   (raw_angle)
   );

   mff_angle u_mean_angle (
      .clock   (clock),
      .advance (advance),
      .cfg     (cfg_ff),
      .pos     (pos_mean[POS_W-1:0]),
      .wrapped (mean_wrapped),
      .angle   (mean_angle)
   );

   // valid flags down the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], hit};
      end
   end

   // decoded fields and mean speed delayed to the result stage
   always_ff @(posedge clock) begin
      if (advance) begin
         fb_pipe_ff[0] <= fb1;
         for (int i = 1; i < LAT; i++) begin
            fb_pipe_ff[i] <= fb_pipe_ff[i-1];
         end
         mspd_pipe_ff[0] <= $signed(spd_mean[WORD_W-1:0]);
         for (int i = 1; i < ANGLE_STAGES; i++) begin
            mspd_pipe_ff[i] <= mspd_pipe_ff[i-1];
         end
      end
   end

   // result stage word
   always_comb begin
      o_valid                      = vld_ff[LAT-1];
      o_data.pad                   = '0;
      o_data.raw_position          = fb_pipe_ff[LAT-1].raw_position;
      o_data.previous_position     = fb_pipe_ff[LAT-1].previous_position;
      o_data.speed_rpm             = fb_pipe_ff[LAT-1].speed_rpm;
      o_data.torque_current        = fb_pipe_ff[LAT-1].torque_current;
      o_data.temperature           = fb_pipe_ff[LAT-1].temperature;
      o_data.wrapped_position      = raw_wrapped;
      o_data.angle                 = raw_angle;
      o_data.mean_speed            = mspd_pipe_ff[ANGLE_STAGES-1];
      o_data.mean_position_wrapped = mean_wrapped;
      o_data.mean_angle            = mean_angle;
   end

   // skid register: holds a stalled result so the pipeline can step once more
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (advance) begin
         skid_valid_ff <= o_valid && !rsp_tready;
      end else if (rsp_tready) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         skid_data_ff <= o_data;
      end
   end

   assign rsp_tvalid = skid_valid_ff || o_valid;
   assign rsp_tdata  = skid_valid_ff ? skid_data_ff : o_data;

endmodule
